// File: hw/rtl/sle_pkg.sv
// Package: shared types, constants and helpers of the sprite line engine.
`timescale 1ns / 1ps
package sle_pkg;

  localparam int SPRITE_COUNT_DEF    = 64;
  localparam int CHARACTER_COUNT_DEF = 512;
  localparam int CHR_MAX_W           = 10;
  localparam int QUEUE_DEPTH         = 4;
  localparam int CFG_AW              = 5;

  localparam logic [1:0] FUNC_SPRITE  = 2'd0;
  localparam logic [1:0] FUNC_PATTERN = 2'd1;
  localparam logic [1:0] FUNC_LINE    = 2'd2;
  localparam logic [1:0] FUNC_RENDER  = 2'd3;

  localparam logic [2:0] REG_COLOR_MODEL  = 3'd0;
  localparam logic [2:0] REG_COMPAT_MODE  = 3'd1;
  localparam logic [2:0] REG_SCROLL_X     = 3'd2;
  localparam logic [2:0] REG_SCROLL_Y     = 3'd3;
  localparam logic [2:0] REG_MONO_PALETTE = 3'd4;
  localparam logic [2:0] REG_COMPAT_BASE  = 3'd5;
  localparam logic [2:0] REG_NATIVE_BASE  = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] slot;
    logic [7:0]  position;
    logic [15:0] pattern;
    logic [8:0]  tile_char;
    logic [1:0]  sprite_priority;
    logic        palette_pick;
    logic [3:0]  color_code;
    logic [7:0]  offset_x;
    logic [7:0]  offset_y;
    logic [3:0]  flip_chain;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] pixel_priority;
    logic [7:0] color_value;
  } out_item_t;

  typedef struct packed {
    logic        color_model;
    logic        compat_mode;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
    logic [23:0] mono_palette;
    logic [7:0]  compat_base;
    logic [7:0]  native_base;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_SPRITE,
    OP_PATTERN,
    OP_LINE,
    OP_RENDER
  } op_t;

  // sprite attribute entry, character already reduced modulo the character count
  typedef struct packed {
    logic [CHR_MAX_W-1:0] chr;
    logic [1:0]           prio;
    logic                 pal;
    logic [3:0]           code;
    logic [7:0]           ox;
    logic [7:0]           oy;
    logic [3:0]           flags;
  } sprite_t;

  typedef struct packed {
    logic [CHR_MAX_W-1:0] chr;
    logic [1:0]           prio;
    logic                 pal;
    logic                 hflip;
    logic [3:0]           code;
    logic [7:0]           x;
    logic [2:0]           row;
  } tile_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] slot;
    logic [7:0]  position;
    logic [15:0] pattern;
    sprite_t     spr;
  } queue_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BRD,
    ST_BPROC,
    ST_RRD,
    ST_RCHK,
    ST_RPAT,
    ST_OUT
  } state_t;

  // chr < 512 and divisor >= 16, so the quotient fits in five bits
  function automatic logic [CHR_MAX_W-1:0] chr_mod(input logic [8:0] chr,
                                                    input logic [10:0] divisor);
    logic [15:0] rem;
    logic [15:0] sub;
    rem = {7'd0, chr};
    for (int k = 4; k >= 0; k--) begin
      sub = {5'd0, divisor} << k;
      if (rem >= sub) begin
        rem = rem - sub;
      end
    end
    return rem[CHR_MAX_W-1:0];
  endfunction

endpackage

// File: hw/rtl/sle_fifo.sv
// Short command queue between the front decoder and the back executor.
`timescale 1ns / 1ps
module sle_fifo
  import sle_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  queue_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   pop_valid,
  output queue_t pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  queue_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/sle_front.sv
// Front end: takes input transfers, decodes them and drops out-of-range writes.
`timescale 1ns / 1ps
module sle_front
  import sle_pkg::*;
#(
  parameter int SPRITE_COUNT    = SPRITE_COUNT_DEF,
  parameter int CHARACTER_COUNT = CHARACTER_COUNT_DEF
) (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output queue_t   q_data
);

  localparam logic [13:0] PAT_LIMIT = 14'(CHARACTER_COUNT * 8);
  localparam logic [12:0] SPR_LIMIT = 13'(SPRITE_COUNT);

  logic accept;
  logic keep;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    q_data.slot      = in_item.slot;
    q_data.position  = in_item.position;
    q_data.pattern   = in_item.pattern;
    q_data.spr.chr   = chr_mod(in_item.tile_char, 11'(CHARACTER_COUNT));
    q_data.spr.prio  = in_item.sprite_priority;
    q_data.spr.pal   = in_item.palette_pick;
    q_data.spr.code  = in_item.color_code;
    q_data.spr.ox    = in_item.offset_x;
    q_data.spr.oy    = in_item.offset_y;
    q_data.spr.flags = in_item.flip_chain;
    case (in_item.func)
      FUNC_SPRITE: begin
        q_data.op = OP_SPRITE;
        keep      = ({1'b0, in_item.slot} < SPR_LIMIT);
      end
      FUNC_PATTERN: begin
        q_data.op = OP_PATTERN;
        keep      = ({2'b0, in_item.slot} < PAT_LIMIT);
      end
      FUNC_LINE: begin
        q_data.op = OP_LINE;
        keep      = 1'b1;
      end
      default: begin
        q_data.op = OP_RENDER;
        keep      = 1'b1;
      end
    endcase
  end

  assign q_push = accept && keep;

endmodule

// File: hw/rtl/sle_back.sv
// Back end: sprite table, pattern memory, line cache walk and pixel render.
`timescale 1ns / 1ps
module sle_back
  import sle_pkg::*;
#(
  parameter int SPRITE_COUNT    = SPRITE_COUNT_DEF,
  parameter int CHARACTER_COUNT = CHARACTER_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  queue_t    q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int SPR_AW    = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int CNT_W     = $clog2(SPRITE_COUNT + 1);
  localparam int CHR_W     = $clog2(CHARACTER_COUNT);
  localparam int PAT_AW    = CHR_W + 3;
  localparam int PAT_DEPTH = CHARACTER_COUNT * 8;

  state_t state_r, state_nxt;

  sprite_t           spr_mem [SPRITE_COUNT];
  logic [SPRITE_COUNT-1:0] spr_vld_r;
  sprite_t           spr_rd_r;
  logic              spr_rdv_r;
  tile_t             tile_mem [SPRITE_COUNT];
  tile_t             tile_rd_r;
  logic [15:0]       pat_mem [PAT_DEPTH];
  logic [15:0]       pat_rd_r;

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        pos_r, pos_nxt;
  logic              prev_r, prev_nxt;
  logic [7:0]        px_r, px_nxt, py_r, py_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r;
  out_item_t         out_item_r;

  // datapath strobes
  logic              spr_we, pat_we, tile_we, out_load;
  logic [7:0]        sx, sy, tx, ty, dx;
  logic [2:0]        xs;
  logic [1:0]        pix;
  logic [2:0]        mono_val;
  logic [7:0]        color;
  logic              tile_on_line;
  tile_t             tile_new;
  logic [PAT_AW-1:0] pat_ra;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // begin-line arithmetic for the sprite just read
  always_comb begin
    sx = spr_rd_r.ox;
    sy = spr_rd_r.oy;
    if (spr_rd_r.flags[2] && prev_r) sx = spr_rd_r.ox + px_r;
    if (spr_rd_r.flags[3] && prev_r) sy = spr_rd_r.oy + py_r;
    tx = sx + cfg.scroll_x + 8'd7;
    ty = sy + cfg.scroll_y + 8'd7 - pos_r;
    tile_on_line   = (ty < 8'd8);
    tile_new.chr   = spr_rd_r.chr;
    tile_new.prio  = spr_rd_r.prio;
    tile_new.pal   = spr_rd_r.pal;
    tile_new.hflip = spr_rd_r.flags[0];
    tile_new.code  = spr_rd_r.code;
    tile_new.x     = tx;
    tile_new.row   = spr_rd_r.flags[1] ? ty[2:0] : ty[2:0] ^ 3'd7;
  end

  // render arithmetic for the cached tile just read
  always_comb begin
    dx     = tile_rd_r.x - pos_r;
    xs     = dx[2:0] ^ {3{tile_rd_r.hflip}};
    pix    = pat_rd_r[{xs, 1'b0} +: 2];
    pat_ra = {tile_rd_r.chr[CHR_W-1:0], tile_rd_r.row};
    mono_val = cfg.mono_palette[{tile_rd_r.pal, 2'b00} * 5'd3 + {3'd0, pix} * 5'd3 +: 3];
    if (!cfg.color_model) begin
      color = {5'd0, mono_val};
    end else if (cfg.compat_mode) begin
      color = cfg.compat_base + {4'd0, tile_rd_r.pal, 3'd0} + {5'd0, mono_val};
    end else begin
      color = cfg.native_base + {2'd0, tile_rd_r.code, 2'd0} + {6'd0, pix};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_data.op == OP_LINE) state_nxt = ST_BRD;
          else if (q_data.op == OP_RENDER) state_nxt = ST_RRD;
        end
      end
      ST_BRD: state_nxt = ST_BPROC;
      ST_BPROC: begin
        if (idx_r == CNT_W'(SPRITE_COUNT - 1)) state_nxt = ST_IDLE;
        else state_nxt = ST_BRD;
      end
      ST_RRD: begin
        if (idx_r == cnt_r) state_nxt = ST_OUT;
        else state_nxt = ST_RCHK;
      end
      ST_RCHK: begin
        if (dx < 8'd8) state_nxt = ST_RPAT;
        else state_nxt = ST_RRD;
      end
      ST_RPAT: begin
        if (pix != 2'd0) state_nxt = ST_OUT;
        else state_nxt = ST_RRD;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and register updates
  always_comb begin
    q_pop    = 1'b0;
    spr_we   = 1'b0;
    pat_we   = 1'b0;
    tile_we  = 1'b0;
    out_load = 1'b0;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    res_nxt  = res_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          pos_nxt = q_data.position;
          idx_nxt = '0;
          case (q_data.op)
            OP_SPRITE:  spr_we = 1'b1;
            OP_PATTERN: pat_we = 1'b1;
            OP_LINE: begin
              cnt_nxt  = '0;
              prev_nxt = 1'b0;
            end
            default: res_nxt = '0;
          endcase
        end
      end
      ST_BPROC: begin
        idx_nxt = idx_r + CNT_W'(1);
        if (spr_rdv_r && spr_rd_r.prio != 2'd0) begin
          prev_nxt = 1'b1;
          px_nxt   = sx;
          py_nxt   = sy;
          if (tile_on_line) begin
            tile_we = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_RCHK: begin
        if (dx >= 8'd8) idx_nxt = idx_r + CNT_W'(1);
      end
      ST_RPAT: begin
        if (pix != 2'd0) begin
          res_nxt.hit            = 1'b1;
          res_nxt.pixel_priority = tile_rd_r.prio;
          res_nxt.color_value    = color;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_OUT: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spr_vld_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (spr_we) spr_vld_r[q_data.slot[SPR_AW-1:0]] <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    prev_r <= prev_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    res_r  <= res_nxt;
    if (out_load) out_item_r <= res_r;
  end

  // sprite table: never-written entries read as hidden
  always_ff @(posedge clk) begin
    if (spr_we) spr_mem[q_data.slot[SPR_AW-1:0]] <= q_data.spr;
    spr_rd_r  <= spr_mem[idx_r[SPR_AW-1:0]];
    spr_rdv_r <= spr_vld_r[idx_r[SPR_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tile_we) tile_mem[cnt_r[SPR_AW-1:0]] <= tile_new;
    tile_rd_r <= tile_mem[idx_r[SPR_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[PAT_AW'(q_data.slot)] <= q_data.pattern;
    pat_rd_r <= pat_mem[pat_ra];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SPRITE_COUNT))
    else $error("line tile count above sprite count");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE)
    else $error("queue popped while busy");

  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("result load did not complete");

  a_idx_render: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RCHK || state_r == ST_RPAT) |-> idx_r < cnt_r)
    else $error("render index past cached tiles");

endmodule

// File: hw/rtl/sprite_line_engine_unit.sv
// Top level: configuration registers, front decoder, queue and back executor.
// Begin line walks the whole sprite table, reading and then processing each entry.
// Render scans the cached tiles (read, x check, pattern check) until a pixel hit; a miss ends with the end check.
// Flow: one queued item at a time in the back end; the front takes transfers
// while the 4-entry queue has room. Result held in an output register.
// Reset: rst_n synchronous active low clears control, registers and sprite valid bits.
`timescale 1ns / 1ps
module sprite_line_engine_unit
  import sle_pkg::*;
#(
  parameter int SPRITE_COUNT    = SPRITE_COUNT_DEF,
  parameter int CHARACTER_COUNT = CHARACTER_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t   cfg_r;
  logic   cfg_we;
  logic   q_full, q_push, q_pop, q_valid;
  queue_t q_in, q_out;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_COLOR_MODEL:  cfg_r.color_model  <= pwdata[0];
        REG_COMPAT_MODE:  cfg_r.compat_mode  <= pwdata[0];
        REG_SCROLL_X:     cfg_r.scroll_x     <= pwdata[7:0];
        REG_SCROLL_Y:     cfg_r.scroll_y     <= pwdata[7:0];
        REG_MONO_PALETTE: cfg_r.mono_palette <= pwdata[23:0];
        REG_COMPAT_BASE:  cfg_r.compat_base  <= pwdata[7:0];
        REG_NATIVE_BASE:  cfg_r.native_base  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_COLOR_MODEL:  prdata = {31'd0, cfg_r.color_model};
      REG_COMPAT_MODE:  prdata = {31'd0, cfg_r.compat_mode};
      REG_SCROLL_X:     prdata = {24'd0, cfg_r.scroll_x};
      REG_SCROLL_Y:     prdata = {24'd0, cfg_r.scroll_y};
      REG_MONO_PALETTE: prdata = {8'd0, cfg_r.mono_palette};
      REG_COMPAT_BASE:  prdata = {24'd0, cfg_r.compat_base};
      REG_NATIVE_BASE:  prdata = {24'd0, cfg_r.native_base};
      default:          prdata = '0;
    endcase
  end

  sle_front #(
    .SPRITE_COUNT    (SPRITE_COUNT),
    .CHARACTER_COUNT (CHARACTER_COUNT)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  sle_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  sle_back #(
    .SPRITE_COUNT    (SPRITE_COUNT),
    .CHARACTER_COUNT (CHARACTER_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
